[hdl/keyed_byte_stream_cipher_core_defines.svh]
// Assertion macros shared by the cipher core RTL.
// Define NO_ASSERTIONS to compile the checks out; no other dependencies.
`ifndef KEYED_BYTE_STREAM_CIPHER_CORE_DEFINES_SVH
`define KEYED_BYTE_STREAM_CIPHER_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, checked outside reset.
`define KBSC_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, checked outside reset.
`define KBSC_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define KBSC_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define KBSC_ASSERT_NXT(label, clk, rst, ante, cons, msg)
`endif
`endif

[hdl/kbsc_pkg.sv]
// Shared constants, register codes and controller/datapath interface types
// for the keyed byte stream cipher core. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package kbsc_pkg;

  localparam int DATA_W        = 8;
  localparam int MIX_W         = 16;
  localparam int GEN_W         = 24;
  localparam int BIT_W         = 4;   // indexes the MIX_W bits of the fold dividend
  localparam int LEN_W         = 6;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 64;
  localparam int KEY_BYTES_DEF = 32;

  localparam logic [MIX_W-1:0]  MIX_INIT      = 16'd257;
  localparam logic [MIX_W-1:0]  MIX_MAX       = 16'd8417;
  localparam logic [GEN_W-1:0]  GEN_ONE_INIT  = 24'd11;
  localparam logic [GEN_W-1:0]  GEN_TWO_INIT  = 24'd13;
  localparam logic [MIX_W:0]    GEN_ONE_ADD   = 17'd5;
  localparam logic [MIX_W:0]    GEN_TWO_ADD   = 17'd7;
  localparam logic [LEN_W-1:0]  KEY_LEN_RESET = 6'd32;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LENGTH = 3'd4;

  typedef struct packed {
    logic             start_item;   // load the accepted data byte
    logic             start_setup;  // restart mix, generators and key index
    logic             div_step;     // one restoring remainder step
    logic [BIT_W-1:0] bit_idx;      // dividend bit consumed by div_step
    logic             setup_sel;    // key byte read by setup counter
    logic             fold;         // add remainder into mix, next key byte
    logic             sum;          // mix plus current key byte
    logic             mul;          // generator update
    logic             load_out;     // write the output register
  } kbsc_cmd_t;

  typedef struct packed {
    logic setup_last;               // setup counter is on the last key byte
  } kbsc_status_t;

endpackage
`default_nettype wire

[hdl/kbsc_ctrl.sv]
// Sequencer for the cipher core: key setup loop, per-byte steps, output valid.
// Depends on kbsc_pkg and keyed_byte_stream_cipher_core_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "keyed_byte_stream_cipher_core_defines.svh"
module kbsc_ctrl
  import kbsc_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic         first,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  input  wire kbsc_status_t status,
  output kbsc_cmd_t         cmd
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV  = 3'd1;
  localparam logic [2:0] ST_FOLD = 3'd2;
  localparam logic [2:0] ST_SUM  = 3'd3;
  localparam logic [2:0] ST_MUL  = 3'd4;
  localparam logic [2:0] ST_OUT  = 3'd5;

  logic [2:0]       state;
  logic [2:0]       state_next;
  logic [BIT_W-1:0] bit_cnt;
  logic [BIT_W-1:0] bit_cnt_next;
  logic             m_tvalid_next;
  logic             accept;
  logic             out_free;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    state_next       = state;
    bit_cnt_next     = bit_cnt;
    cmd              = '0;
    cmd.bit_idx      = bit_cnt;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          cmd.start_item = 1'b1;
          if (first) begin
            cmd.start_setup = 1'b1;
            bit_cnt_next    = '1;
            state_next      = ST_DIV;
          end else begin
            cmd.sum    = 1'b1;
            state_next = ST_MUL;
          end
        end
      end
      ST_DIV: begin
        cmd.div_step  = 1'b1;
        cmd.setup_sel = 1'b1;
        bit_cnt_next  = bit_cnt - BIT_W'(1);
        if (bit_cnt == '0) begin
          state_next = ST_FOLD;
        end
      end
      ST_FOLD: begin
        cmd.fold     = 1'b1;
        bit_cnt_next = '1;
        state_next   = status.setup_last ? ST_SUM : ST_DIV;
      end
      ST_SUM: begin
        cmd.sum    = 1'b1;
        state_next = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul      = 1'b1;
        cmd.load_out = out_free;
        state_next   = out_free ? ST_IDLE : ST_OUT;
      end
      ST_OUT: begin
        cmd.load_out = out_free;
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    m_tvalid_next = m_tvalid;
    if (cmd.load_out) begin
      m_tvalid_next = 1'b1;
    end else if (m_tready) begin
      m_tvalid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      bit_cnt  <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      bit_cnt  <= bit_cnt_next;
      m_tvalid <= m_tvalid_next;
    end
  end

  `KBSC_ASSERT_IMP(a_out_wait_full, clk, rst, state == ST_OUT, m_tvalid,
                   "held result lost its valid")
  `KBSC_ASSERT_NXT(a_fold_after_div, clk, rst, (state == ST_DIV) && (bit_cnt == '0),
                   state == ST_FOLD, "remainder loop did not end in fold")
  `KBSC_ASSERT_NXT(a_mul_exit, clk, rst, state == ST_MUL,
                   (state == ST_IDLE) || (state == ST_OUT),
                   "multiply step did not hand off result")

endmodule
`default_nettype wire

[hdl/kbsc_datapath.sv]
// Key store, remainder unit, mixing value, generators and output register.
// Depends on kbsc_pkg and keyed_byte_stream_cipher_core_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "keyed_byte_stream_cipher_core_defines.svh"
module kbsc_datapath
  import kbsc_pkg::*;
#(
  parameter int KEY_BYTES = KEY_BYTES_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic [DATA_W-1:0]     data_byte,
  input  wire kbsc_cmd_t             cmd,
  output kbsc_status_t               status,
  output logic [DATA_W-1:0]          cipher_byte
);

  localparam int IDX_W = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(KEY_BYTES);

  logic [DATA_W-1:0] key_bytes [KEY_BYTES];
  logic [LEN_W-1:0]  key_length;
  logic [LEN_W-1:0]  len_eff;

  logic [MIX_W-1:0]  mix_value;
  logic [MIX_W-1:0]  mix_sum;
  logic [GEN_W-1:0]  gen_one;
  logic [GEN_W-1:0]  gen_two;
  logic [IDX_W-1:0]  key_index;
  logic [IDX_W-1:0]  setup_idx;
  logic [DATA_W-1:0] rem;
  logic [DATA_W-1:0] data_q;

  logic [IDX_W-1:0]  kidx_eff;
  logic [LEN_W-1:0]  kidx_inc;
  logic [IDX_W-1:0]  kidx_next;
  logic [IDX_W-1:0]  key_sel;
  logic [DATA_W-1:0] key_byte;
  logic [DATA_W:0]   divisor;
  logic [DATA_W:0]   rem_shift;
  logic [DATA_W-1:0] rem_next;
  logic [MIX_W:0]    add_one;
  logic [MIX_W:0]    add_two;
  logic [GEN_W:0]    prod_one;
  logic [GEN_W:0]    prod_two;
  logic [GEN_W-1:0]  gen_one_next;
  logic [GEN_W-1:0]  gen_two_next;

  // Key bytes: each config word feeds eight byte slots, slots past KEY_BYTES dropped
  for (genvar b = 0; b < KEY_BYTES; b++) begin : g_key
    localparam logic [CFG_IDX_W-1:0] WORD_OFS = CFG_IDX_W'(b / 8);
    always_ff @(posedge clk) begin
      if (rst) begin
        key_bytes[b] <= '0;
      end else if (cfg_we && (cfg_index == REG_KEY_WORD_0 + WORD_OFS)) begin
        key_bytes[b] <= cfg_data[(b % 8) * DATA_W +: DATA_W];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_length <= KEY_LEN_RESET;
    end else if (cfg_we && (cfg_index == REG_KEY_LENGTH)) begin
      key_length <= cfg_data[LEN_W-1:0];
    end
  end

  // Clamp length to 1..KEY_BYTES
  always_comb begin
    len_eff = key_length;
    if (key_length == '0) begin
      len_eff = LEN_W'(1);
    end else if (key_length > MAX_LEN) begin
      len_eff = MAX_LEN;
    end
  end

  // Stale index (length lowered mid-message) restarts at key byte 0
  assign kidx_eff  = (LEN_W'(key_index) >= len_eff) ? '0 : key_index;
  assign kidx_inc  = LEN_W'(kidx_eff) + LEN_W'(1);
  assign kidx_next = (kidx_inc >= len_eff) ? '0 : kidx_inc[IDX_W-1:0];

  assign key_sel  = cmd.setup_sel ? setup_idx : kidx_eff;
  assign key_byte = key_bytes[key_sel];

  assign status.setup_last = ((LEN_W'(setup_idx) + LEN_W'(1)) == len_eff);

  // Restoring remainder step: mix mod (key byte + 1), one dividend bit a cycle
  assign divisor   = {1'b0, key_byte} + (DATA_W+1)'(1);
  assign rem_shift = {rem, mix_value[cmd.bit_idx]};
  assign rem_next  = (rem_shift >= divisor) ? DATA_W'(rem_shift - divisor)
                                            : rem_shift[DATA_W-1:0];

  // Generators: g = (mix_sum + c) * (g & 255) + (g >> 8), with mix_sum = mix + key byte
  assign add_one      = {1'b0, mix_sum} + GEN_ONE_ADD;
  assign add_two      = {1'b0, mix_sum} + GEN_TWO_ADD;
  assign prod_one     = (GEN_W+1)'(add_one) * (GEN_W+1)'(gen_one[DATA_W-1:0]);
  assign prod_two     = (GEN_W+1)'(add_two) * (GEN_W+1)'(gen_two[DATA_W-1:0]);
  assign gen_one_next = prod_one[GEN_W-1:0] + GEN_W'(gen_one[GEN_W-1:DATA_W]);
  assign gen_two_next = prod_two[GEN_W-1:0] + GEN_W'(gen_two[GEN_W-1:DATA_W]);

  always_ff @(posedge clk) begin
    if (rst) begin
      mix_value <= MIX_INIT;
      gen_one   <= GEN_ONE_INIT;
      gen_two   <= GEN_TWO_INIT;
      key_index <= '0;
    end else begin
      if (cmd.start_setup) begin
        mix_value <= MIX_INIT;
        gen_one   <= GEN_ONE_INIT;
        gen_two   <= GEN_TWO_INIT;
        key_index <= '0;
      end else if (cmd.fold) begin
        mix_value <= mix_value + MIX_W'(rem);
      end else if (cmd.sum) begin
        key_index <= kidx_next;
      end else if (cmd.mul) begin
        gen_one   <= gen_one_next;
        gen_two   <= gen_two_next;
        mix_value <= MIX_W'(gen_two_next[DATA_W-1:0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_item) begin
      data_q <= data_byte;
    end
    if (cmd.start_setup || cmd.fold) begin
      rem <= '0;
    end else if (cmd.div_step) begin
      rem <= rem_next;
    end
    if (cmd.start_setup) begin
      setup_idx <= '0;
    end else if (cmd.fold) begin
      setup_idx <= setup_idx + IDX_W'(1);
    end
    if (cmd.sum) begin
      mix_sum <= mix_value + MIX_W'(key_byte);
    end
    if (cmd.load_out) begin
      cipher_byte <= data_q ^ (cmd.mul ? gen_two_next[DATA_W-1:0]
                                       : mix_value[DATA_W-1:0]);
    end
  end

  `KBSC_ASSERT_IMP(a_mix_bound, clk, rst, 1'b1, mix_value <= MIX_MAX,
                   "mixing value above its bound")
  `KBSC_ASSERT_IMP(a_gen_bound, clk, rst, 1'b1,
                   (gen_one[GEN_W-1:GEN_W-2] == 2'b00) && (gen_two[GEN_W-1:GEN_W-2] == 2'b00),
                   "generator above its bound")

endmodule
`default_nettype wire

[hdl/keyed_byte_stream_cipher_core.sv]
// Keyed byte stream cipher core: top level joining sequencer and datapath.
// Depends on kbsc_pkg, kbsc_ctrl and kbsc_datapath.
// Byte without a first mark: accept (with the key byte sum), then generator multiply;
//   cipher_byte is registered once the output is free, and no byte is accepted before.
// First byte: key setup runs 16 remainder steps and one fold per key byte in use
//   in the bit-serial remainder unit, then the sum and the multiply.
// Reset (rst, synchronous): key words 0, key length 32, mix 257, generators 11/13.
`timescale 1ns / 1ps
`default_nettype none
module keyed_byte_stream_cipher_core
  import kbsc_pkg::*;
#(
  parameter int KEY_BYTES = KEY_BYTES_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // Configuration write port
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  // Plaintext stream
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [DATA_W-1:0]     s_tdata,   // [7:0] data_byte
  input  wire logic                  s_tuser,   // [0] first
  // Ciphertext stream
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [DATA_W-1:0]          m_tdata    // [7:0] cipher_byte
);

  kbsc_cmd_t    cmd;
  kbsc_status_t status;

  // Sequencer: accept one transfer at a time, run key setup on a first mark,
  // then sum, multiply and hand the result to the output register. Once loaded, the
  // output register frees the input side while its result waits for its transfer.
  kbsc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .first    (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // Datapath: key store, remainder unit, mixing value, generators.
  kbsc_datapath #(
    .KEY_BYTES (KEY_BYTES)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .data_byte   (s_tdata),
    .cmd         (cmd),
    .status      (status),
    .cipher_byte (m_tdata)
  );

endmodule
`default_nettype wire
